// ----- src/ccu_pkg.sv -----
// Shared constants and types for the coprime counter.
// No dependencies; every other design file imports this package, the checker aside.
package ccu_pkg;

    localparam int VALUE_IN_W = 32;
    localparam int LIMIT_W    = 32;
    localparam int COUNT_W    = 32;

    // Queue status seen by the factoring front and the counting back.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ----- src/ccu_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but the package import style of the project.
module ccu_div
    import ccu_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_reg, q_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            r_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_reg <= {q_reg[NW-2:0], fits};
        end
        else if (start)
        begin
            q_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- src/ccu_fifo.sv -----
// Two-word job queue between the factoring front and the counting back.
// Depends on ccu_pkg for the status struct.
module ccu_fifo
    import ccu_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output fifo_stat_t   stat
);

    logic [W-1:0] mem [2];
    logic         wr_reg;
    logic         rd_reg;
    logic [1:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wdata;
    end

    assign rdata      = mem[rd_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

endmodule

// ----- src/ccu_front.sv -----
// Front: takes a word, finds the distinct primes of the value by trial
// division and queues them with the limit. Uses ccu_div and ccu_pkg.
module ccu_front
    import ccu_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_PRIMES = 9,
    parameter int NB         = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [VALUE_IN_W-1:0]                value,
    input  logic [LIMIT_W-1:0]                   limit,
    output logic                                 busy,
    input  fifo_stat_t                           qstat,
    output logic                                 push,
    output logic [LIMIT_W-1:0]                   job_limit,
    output logic [NB-1:0]                        job_n,
    output logic [MAX_PRIMES-1:0][VALUE_BITS-1:0] job_primes
);

    localparam int VB = VALUE_BITS;
    localparam int SW = VALUE_BITS + 2;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]                           state_reg;
    logic [VB-1:0]                        v_reg;
    logic [VB-1:0]                        d_reg;
    logic [SW-1:0]                        sq_reg;
    logic                                 found_reg;
    logic [NB-1:0]                        n_reg;
    logic [LIMIT_W-1:0]                   lim_reg;
    logic [MAX_PRIMES-1:0][VB-1:0]        primes_reg;

    logic          div_start;
    logic [VB-1:0] div_num;
    logic          div_done;
    logic [VB-1:0] div_quot;
    logic [VB-1:0] div_rem;
    logic          room;

    assign room = (n_reg < NB'(MAX_PRIMES));

    always_comb
    begin
        div_start = 1'b0;
        div_num   = v_reg;
        if (state_reg == F_CHECK && ({2'b00, v_reg} >= sq_reg))
            div_start = 1'b1;
        else if (state_reg == F_DIV && div_done && div_rem == '0)
        begin
            // keep dividing out the same prime
            div_start = 1'b1;
            div_num   = div_quot;
        end
    end

    ccu_div #(.NW(VB), .DW(VB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
        begin
            case (state_reg)
                F_IDLE:
                    if (start)
                        state_reg <= F_CHECK;
                F_CHECK:
                    if ({2'b00, v_reg} < sq_reg)
                        state_reg <= F_PUSH;
                    else
                        state_reg <= F_DIV;
                F_DIV:
                    if (div_done && div_rem != '0)
                        state_reg <= F_CHECK;
                F_PUSH:
                    if (!qstat.full)
                        state_reg <= F_IDLE;
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
                if (start)
                begin
                    v_reg     <= VB'(value);
                    lim_reg   <= limit;
                    d_reg     <= VB'(2);
                    sq_reg    <= SW'(4);
                    found_reg <= 1'b0;
                    n_reg     <= '0;
                end
            F_CHECK:
                if ({2'b00, v_reg} < sq_reg && v_reg > VB'(1) && room)
                begin
                    // leftover cofactor is itself prime
                    primes_reg[n_reg] <= v_reg;
                    n_reg             <= n_reg + 1'b1;
                end
            F_DIV:
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        v_reg     <= div_quot;
                        found_reg <= 1'b1;
                        if (!found_reg && room)
                        begin
                            primes_reg[n_reg] <= d_reg;
                            n_reg             <= n_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        d_reg     <= d_reg + 1'b1;
                        sq_reg    <= sq_reg + {1'b0, d_reg, 1'b1};
                    end
                end
            default:
                ;
        endcase
    end

    assign busy       = (state_reg != F_IDLE);
    assign push       = (state_reg == F_PUSH) && !qstat.full;
    assign job_limit  = lim_reg;
    assign job_n      = n_reg;
    assign job_primes = primes_reg;

endmodule

// ----- src/ccu_back.sv -----
// Back: runs inclusion-exclusion over the queued primes and strobes
// out the count. Uses ccu_div and ccu_pkg.
module ccu_back
    import ccu_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_PRIMES = 9,
    parameter int NB         = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fifo_stat_t                            qstat,
    output logic                                  pop,
    input  logic [LIMIT_W-1:0]                    job_limit,
    input  logic [NB-1:0]                         job_n,
    input  logic [MAX_PRIMES-1:0][VALUE_BITS-1:0] job_primes,
    output logic                                  done,
    output logic [COUNT_W-1:0]                    coprime_count
);

    localparam int VB = VALUE_BITS;
    localparam int SW = MAX_PRIMES + 1;
    localparam int IB = $clog2(MAX_PRIMES);
    localparam int AW = LIMIT_W + MAX_PRIMES + 2;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;

    logic [1:0]                    state_reg;
    logic [SW-1:0]                 s_reg;
    logic [NB-1:0]                 k_reg;
    logic [NB-1:0]                 n_reg;
    logic                          odd_reg;
    logic [LIMIT_W-1:0]            q_reg;
    logic [LIMIT_W-1:0]            lim_reg;
    logic signed [AW-1:0]          total_reg;
    logic [MAX_PRIMES-1:0][VB-1:0] primes_reg;
    logic                          done_reg;
    logic [COUNT_W-1:0]            count_reg;

    logic                 at_end;
    logic                 last_set;
    logic                 cur_bit;
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] sum;
    logic                 div_start;
    logic                 div_done;
    logic [LIMIT_W-1:0]   div_quot;
    logic [VB-1:0]        div_rem;

    assign at_end   = (k_reg == n_reg);
    assign last_set = ((s_reg + 1'b1) == (SW'(1) << n_reg));
    assign cur_bit  = s_reg[k_reg];
    assign term     = AW'($signed({1'b0, q_reg}));
    assign sum      = odd_reg ? total_reg - term : total_reg + term;
    assign div_start = (state_reg == B_SCAN) && !at_end && cur_bit && (q_reg != '0);
    assign pop      = (state_reg == B_IDLE) && !qstat.empty;

    ccu_div #(.NW(LIMIT_W), .DW(VB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg),
        .den   (primes_reg[k_reg[IB-1:0]]),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                    if (!qstat.empty)
                        state_reg <= B_SCAN;
                B_SCAN:
                    if (at_end && last_set)
                    begin
                        state_reg <= B_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else if (div_start)
                        state_reg <= B_DIV;
                B_DIV:
                    if (div_done)
                        state_reg <= B_SCAN;
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (!qstat.empty)
                begin
                    lim_reg    <= job_limit;
                    q_reg      <= job_limit;
                    n_reg      <= job_n;
                    primes_reg <= job_primes;
                    s_reg      <= '0;
                    k_reg      <= '0;
                    odd_reg    <= 1'b0;
                    total_reg  <= '0;
                end
            B_SCAN:
                if (at_end)
                begin
                    // fold this subset's quotient in, then move on
                    total_reg <= sum;
                    s_reg     <= s_reg + 1'b1;
                    k_reg     <= '0;
                    q_reg     <= lim_reg;
                    odd_reg   <= 1'b0;
                    if (last_set)
                        count_reg <= (sum < 0) ? '0 : COUNT_W'(sum);
                end
                else
                begin
                    if (cur_bit)
                        odd_reg <= ~odd_reg;
                    if (!div_start)
                        k_reg <= k_reg + 1'b1;
                end
            B_DIV:
                if (div_done)
                begin
                    q_reg <= div_quot;
                    k_reg <= k_reg + 1'b1;
                end
            default:
                ;
        endcase
    end

    assign done          = done_reg;
    assign coprime_count = count_reg;

endmodule

// ----- src/coprime_count_upto.sv -----
// Factoring tries each divisor from 2 up to sqrt(value) on the bit-serial
// divider. Counting then runs over every subset of the n distinct primes.
// Throughput: the front takes a new word once the previous one is queued.
// Reset (rst_n, async low) clears all control state; done stays low.
// The receiver cannot stall: done pulses for one cycle with the count.
module coprime_count_upto
    import ccu_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_PRIMES = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_IN_W-1:0] value,
    input  logic [LIMIT_W-1:0]    limit,
    output logic                  done,
    output logic [COUNT_W-1:0]    coprime_count
);

    localparam int NB = $clog2(MAX_PRIMES + 1);
    localparam int JW = LIMIT_W + NB + MAX_PRIMES * VALUE_BITS;

    fifo_stat_t qstat;
    logic       push;
    logic       pop;
    logic [JW-1:0] wdata;
    logic [JW-1:0] rdata;

    logic [LIMIT_W-1:0]                    f_limit;
    logic [NB-1:0]                         f_n;
    logic [MAX_PRIMES-1:0][VALUE_BITS-1:0] f_primes;
    logic [LIMIT_W-1:0]                    b_limit;
    logic [NB-1:0]                         b_n;
    logic [MAX_PRIMES-1:0][VALUE_BITS-1:0] b_primes;

    // Front: accept a word and factor the value.
    ccu_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PRIMES (MAX_PRIMES),
        .NB         (NB)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .limit      (limit),
        .busy       (busy),
        .qstat      (qstat),
        .push       (push),
        .job_limit  (f_limit),
        .job_n      (f_n),
        .job_primes (f_primes)
    );

    // Queue: hold up to two factored jobs so both sides run on their own.
    assign wdata = {f_limit, f_n, f_primes};
    assign {b_limit, b_n, b_primes} = rdata;

    ccu_fifo #(.W(JW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .stat  (qstat)
    );

    // Back: inclusion-exclusion over the subsets, one result strobe per job.
    ccu_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PRIMES (MAX_PRIMES),
        .NB         (NB)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .pop           (pop),
        .job_limit     (b_limit),
        .job_n         (b_n),
        .job_primes    (b_primes),
        .done          (done),
        .coprime_count (coprime_count)
    );

endmodule

// ----- src/coprime_count_upto_chk.sv -----
// Port-level checks for the coprime counter, bound to the top level.
// Depends on coprime_count_upto's port list only.
module coprime_count_upto_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] value,
    input logic [31:0] limit,
    input logic        done,
    input logic [31:0] coprime_count
);

    // the front goes busy right after taking a word
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done && !busy)
        else $error("activity out of reset");

endmodule

bind coprime_count_upto coprime_count_upto_chk u_chk (.*);
